// ===== hdl/skdht_pkg.sv =====
// ----------------------------------------------------------------------------
// skdht_pkg: shared types and codes of the string key hash table
// Holds the result status codes, the opcodes and the command record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package skdht_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned STAT_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_OCCUPIED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;

  // One queue entry: either a character to store at position pos, or the
  // end of a name with everything the back end needs to act on it.
  typedef struct packed {
    logic              is_end;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  pos;
    logic              op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic              too_long;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

// ===== hdl/skdht_if.sv =====
// ----------------------------------------------------------------------------
// skdht_in_if / skdht_out_if: channels of the string key hash table
// Valid/ready channels carrying one character beat and one result beat.
// ----------------------------------------------------------------------------
interface skdht_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [6:0]  name_char;
  logic        char_valid;
  logic        last_char;
  logic signed [31:0] book_id;

  modport source (output valid, opcode, name_char, char_valid, last_char, book_id,
                  input ready);
  modport sink (input valid, opcode, name_char, char_valid, last_char, book_id,
                output ready);
endinterface

interface skdht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] found_id;
  logic [5:0]  slot_index;

  modport source (output valid, status, found_id, slot_index, input ready);
  modport sink (input valid, status, found_id, slot_index, output ready);
endinterface

// ===== hdl/skdht_ram.sv =====
// ----------------------------------------------------------------------------
// skdht_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skdht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/skdht_queue.sv =====
// ----------------------------------------------------------------------------
// skdht_queue: two-entry command queue
// Decouples the character front end from the table back end.
// ----------------------------------------------------------------------------
module skdht_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skdht_pkg::cmd_t   push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output skdht_pkg::cmd_t   pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import skdht_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/skdht_front.sv =====
// ----------------------------------------------------------------------------
// skdht_front: character intake and hashing
// Takes character beats, runs the hash h = ((h + c) * c) mod TABLE_SIZE and
// forwards stored characters and the end-of-name command to the queue.
// ----------------------------------------------------------------------------
module skdht_front #(
  parameter int unsigned TABLE_SIZE = 20,
  parameter int unsigned MAX_NAME   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  skdht_in_if.sink        in_i,
  output skdht_pkg::cmd_t cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i
);
  import skdht_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_RED  = 2'd2;
  localparam logic [1:0] F_END  = 2'd3;

  // Reciprocal of TABLE_SIZE; with this shift the quotient of any product
  // below 2**15 comes out exact.
  localparam int unsigned SHIFT  = 24;
  localparam int unsigned RECIP_I = ((1 << SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam logic [23:0] RECIP  = 24'(RECIP_I);
  localparam logic [6:0]  TS     = 7'(TABLE_SIZE);
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_NAME);

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] h_q, h_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              long_q, long_d;
  logic              last_q, op_q;
  logic [ID_W-1:0]   id_q;
  logic [14:0]       x_q, q_q;
  logic              acc, real_char;
  logic [7:0]        sum;
  logic [38:0]       prod;
  logic [14:0]       rem;

  assign in_i.ready = (state_q == F_IDLE) && cmd_ready_i;
  assign acc        = in_i.valid && in_i.ready;
  assign real_char  = in_i.char_valid && (in_i.name_char != 7'd0);

  assign sum  = 8'(h_q) + 8'(in_i.name_char);
  assign prod = 39'(x_q) * 39'(RECIP);
  assign rem  = x_q - 15'(q_q * 15'(TS));

  assign cmd_valid_o = (state_q == F_END) ||
                       (acc && real_char && (len_q < MAXL));

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_end   = (state_q == F_END);
    cmd_o.ch       = in_i.name_char;
    cmd_o.pos      = len_q;
    cmd_o.op       = op_q;
    cmd_o.id       = id_q;
    cmd_o.len      = len_q;
    cmd_o.too_long = long_q;
    cmd_o.slot     = h_q;
  end

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    len_d   = len_q;
    long_d  = long_q;
    unique case (state_q)
      F_IDLE: begin
        if (acc) begin
          if (real_char) begin
            if (len_q < MAXL) begin
              len_d = len_q + 1'b1;
            end else begin
              long_d = 1'b1;
            end
            state_d = F_MUL;
          end else if (in_i.last_char) begin
            state_d = F_END;
          end
        end
      end
      F_MUL: state_d = F_RED;
      F_RED: begin
        h_d     = rem[SLOT_W-1:0];
        state_d = last_q ? F_END : F_IDLE;
      end
      F_END: begin
        if (cmd_ready_i) begin
          h_d     = '0;
          len_d   = '0;
          long_d  = 1'b0;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      h_q     <= '0;
      len_q   <= '0;
      long_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      len_q   <= len_d;
      long_q  <= long_d;
      if (acc) last_q <= in_i.last_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q <= in_i.opcode;
      id_q <= in_i.book_id;
      x_q  <= 15'(sum) * 15'(in_i.name_char);
    end
    q_q <= prod[38:24];
  end

endmodule

// ===== hdl/skdht_back.sv =====
// ----------------------------------------------------------------------------
// skdht_back: table sequencer
// Collects the key characters and, at the end of a name, inserts or looks up
// the hashed slot, comparing or copying the name one character per cycle.
// ----------------------------------------------------------------------------
module skdht_back #(
  parameter int unsigned TABLE_SIZE = 20,
  parameter int unsigned MAX_NAME   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  skdht_pkg::cmd_t cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  skdht_out_if.source     out_o
);
  import skdht_pkg::*;

  localparam int unsigned KW  = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int unsigned SW  = $clog2(TABLE_SIZE);
  localparam int unsigned ND  = TABLE_SIZE * MAX_NAME;
  localparam int unsigned NAW = $clog2(ND);
  localparam int unsigned MW  = ID_W + LEN_W;
  localparam logic [NAW-1:0] MAX_NA = NAW'(MAX_NAME);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_META  = 3'd1;
  localparam logic [2:0] B_CHECK = 3'd2;
  localparam logic [2:0] B_CMP   = 3'd3;
  localparam logic [2:0] B_COPY  = 3'd4;
  localparam logic [2:0] B_FIN   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [TABLE_SIZE-1:0] valid_q, valid_d;
  logic [SW-1:0]         s_q;
  logic                  op_q, long_q;
  logic [ID_W-1:0]       id_q;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      idx_q, idx_d, cp_idx_q, cp_idx_d;
  logic                  pend_q, pend_d;
  logic [STAT_W-1:0]     res_st_q, res_st_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic                  out_v_q;
  logic [STAT_W-1:0]     out_st_q;
  logic [ID_W-1:0]       out_id_q;
  logic [SLOT_W-1:0]     out_slot_q;

  logic                  key_we, meta_we, name_we, pop, load_out;
  logic [CHAR_W-1:0]     key_rd, name_rd;
  logic [MW-1:0]         meta_rd;
  logic [ID_W-1:0]       meta_id;
  logic [LEN_W-1:0]      meta_len;
  logic [NAW-1:0]        base;

  assign cmd_ready_o = (state_q == B_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign key_we      = pop && !cmd_i.is_end;
  assign base        = NAW'(s_q) * MAX_NA;
  assign meta_id     = meta_rd[MW-1:LEN_W];
  assign meta_len    = meta_rd[LEN_W-1:0];
  assign meta_we     = (state_q == B_CHECK) && !long_q && (op_q == OP_INSERT) &&
                       !valid_q[s_q];
  assign name_we     = (state_q == B_COPY) && pend_q;
  assign load_out    = (state_q == B_FIN) && (!out_v_q || out_o.ready);

  skdht_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_NAME)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (cmd_i.pos[KW-1:0]),
    .wdata_i (cmd_i.ch),
    .raddr_i (idx_q[KW-1:0]),
    .rdata_o (key_rd)
  );

  skdht_ram #(.WIDTH(MW), .DEPTH(TABLE_SIZE)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (s_q),
    .wdata_i ({id_q, len_q}),
    .raddr_i (s_q),
    .rdata_o (meta_rd)
  );

  skdht_ram #(.WIDTH(CHAR_W), .DEPTH(ND)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (base + NAW'(cp_idx_q)),
    .wdata_i (key_rd),
    .raddr_i (base + NAW'(idx_q)),
    .rdata_o (name_rd)
  );

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    idx_d    = idx_q;
    cp_idx_d = cp_idx_q;
    pend_d   = pend_q;
    res_st_d = res_st_q;
    res_id_d = res_id_q;
    unique case (state_q)
      B_IDLE: begin
        idx_d  = '0;
        pend_d = 1'b0;
        if (pop && cmd_i.is_end) begin
          state_d = B_META;
        end
      end
      B_META: state_d = B_CHECK;
      B_CHECK: begin
        res_id_d = '0;
        state_d  = B_FIN;
        if (long_q) begin
          res_st_d = ST_TOO_LONG;
        end else if (op_q == OP_INSERT) begin
          if (valid_q[s_q]) begin
            res_st_d = ST_OCCUPIED;
          end else begin
            res_st_d       = ST_INSERTED;
            valid_d[s_q]   = 1'b1;
            if (len_q != '0) state_d = B_COPY;
          end
        end else if (valid_q[s_q] && (meta_len == len_q)) begin
          res_id_d = meta_id;
          res_st_d = ST_FOUND;
          if (len_q != '0) state_d = B_CMP;
        end else begin
          res_st_d = ST_NOT_FOUND;
        end
      end
      B_CMP: begin
        // The read issued last cycle is checked while the next one goes out.
        if (pend_q && (key_rd != name_rd)) begin
          res_st_d = ST_NOT_FOUND;
          res_id_d = '0;
          state_d  = B_FIN;
        end else if (idx_q == len_q) begin
          state_d = B_FIN;
        end else begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
      end
      B_COPY: begin
        if (idx_q == len_q) begin
          pend_d  = 1'b0;
          if (pend_q) state_d = B_FIN;
        end else begin
          cp_idx_d = idx_q;
          idx_d    = idx_q + 1'b1;
          pend_d   = 1'b1;
        end
      end
      B_FIN: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= '0;
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.is_end) begin
      s_q    <= cmd_i.slot[SW-1:0];
      op_q   <= cmd_i.op;
      long_q <= cmd_i.too_long;
      id_q   <= cmd_i.id;
      len_q  <= cmd_i.len;
    end
    idx_q    <= idx_d;
    cp_idx_q <= cp_idx_d;
    res_st_q <= res_st_d;
    res_id_q <= res_id_d;
    if (load_out) begin
      out_st_q   <= res_st_q;
      out_id_q   <= res_id_q;
      out_slot_q <= SLOT_W'(s_q);
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.status     = out_st_q;
  assign out_o.found_id   = out_id_q;
  assign out_o.slot_index = out_slot_q;

endmodule

// ===== hdl/string_key_direct_hash_table.sv =====
// ----------------------------------------------------------------------------
// string_key_direct_hash_table: direct-mapped name/id table
// Hashes a streamed name one character per beat and inserts or looks up the
// id in the slot it maps to, with no collision handling.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat content
//   in_i     in   opcode, name_char, char_valid, last_char, book_id
//   out_o    out  status, found_id, slot_index (one beat per finished name)
//
// A real character beat passes through F_IDLE, F_MUL and F_RED in the front
// end: the hash loop runs one multiply, one reciprocal multiply and a
// subtract per character. Other beats are taken in F_IDLE; a beat that ends
// a name then goes to F_END to push the end-of-name command. At the end of
// a name the back end goes through B_META, B_CHECK and B_FIN before it takes
// the next command, and through B_COPY or B_CMP as well for an insert into an
// empty slot or a lookup that matches length, one character at a time, since
// the name memory has a single read port and a single write.
// Reset clears the slot valid flags at once; there is no clearing pass.
// Both sides stall on their own: a two-entry queue separates the front end
// from the back end, and a full output register holds the back end only.
module string_key_direct_hash_table #(
  parameter int unsigned TABLE_SIZE = 20,
  parameter int unsigned MAX_NAME   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skdht_in_if.sink    in_i,
  skdht_out_if.source out_o
);
  import skdht_pkg::*;

  // Commands from the hashing front end to the queue, and from the queue to
  // the table sequencer.
  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // The front end hashes the name and pushes stored characters and the
  // end-of-name command.
  skdht_front #(.TABLE_SIZE(TABLE_SIZE), .MAX_NAME(MAX_NAME)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  // The queue lets a new name start streaming while the last one is still
  // being compared or copied.
  skdht_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_cmd),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // The back end owns the key buffer, the slot memories and the result
  // register.
  skdht_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_NAME(MAX_NAME)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
